[rtl/fq15_pkg.sv]
package fq15_pkg;

  // Filter geometry
  localparam int TAPS       = 32;
  localparam int MAX_TAPS   = 32;
  localparam int NUM_GROUPS = 8;
  localparam int LANES      = 4;
  localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TAP_IDX_W  = $clog2(MAX_TAPS);

  // Data widths
  localparam int SAMP_W  = 16;
  localparam int COEF_W  = 16;
  localparam int GROUP_W = COEF_W * LANES;
  localparam int PROD_W  = SAMP_W + COEF_W;
  localparam int ACC_W   = 38;
  localparam int CFG_IDX_W = 8;

  // History ring: one slot per tap, the oldest is overwritten by the newest
  localparam int HIST_DEPTH = MAX_TAPS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Rounding and Q30 saturation limits
  localparam logic signed [ACC_W-1:0] ROUND_CONST = ACC_W'(64'sd16384);
  localparam logic signed [ACC_W-1:0] SAT_HI      = ACC_W'(64'sd1073741823);
  localparam logic signed [ACC_W-1:0] SAT_LO      = -ACC_W'(64'sd1073741824);

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic              wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [SAMP_W-1:0] wr_data;
    logic              rd_en;
    logic [HIST_AW-1:0] rd_addr;
  } hist_req_t;

endpackage

[rtl/fq15_hist_mem.sv]
module fq15_hist_mem
  import fq15_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  hist_req_t                req,
  output logic signed [SAMP_W-1:0] rd_data
);

  logic [SAMP_W-1:0]     mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_r;
  logic [SAMP_W-1:0]     rd_q_r;
  logic                  rd_vld_r;

  // Valid bits stand in for clearing the ring at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r   <= mem[req.rd_addr];
      rd_vld_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? $signed(rd_q_r) : '0;

endmodule

[rtl/fq15_mac.sv]
module fq15_mac
  import fq15_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [SAMP_W-1:0] sample,
  input  logic signed [COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     done
);

  mac_ctl_t                  p_ctl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_base;
  logic                      done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
      done_r  <= 1'b0;
    end else begin
      p_ctl_r <= ctl;
      done_r  <= p_ctl_r.vld && p_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * coef;
  end

  // first tap restarts from the rounding constant
  assign acc_base = p_ctl_r.first ? ROUND_CONST : acc_r;

  always_ff @(posedge clk) begin
    if (p_ctl_r.vld) begin
      acc_r <= acc_base + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

[rtl/fir_filter_q15_saturating_unit.sv]
// Q15 FIR filter, 32 taps, one shared multiply-accumulate unit. Each accepted
// request on in_* is one signed Q15 sample; it yields exactly one signed Q15
// result on out_*: sum of coef[k] * x[n-k], plus 2^14 for rounding, clipped to
// [-2^30, 2^30-1] and shifted right by 15. Past samples live in a 32-entry
// ring memory with a registered read; the MAC walks one tap per cycle. From
// acceptance to result a sample passes through the tap issue steps, each
// with its memory read, then the product register, the accumulate, the
// write-back state and the result load, and the filter returns to idle
// after write-back, where it waits for the next sample.
// The filter takes a new sample as soon as the previous one is written back,
// even while the last result still waits in the output register; it stalls
// at write-back only if that register is still full. Coefficients sit in
// eight 64-bit registers written over cfg_*, four taps each, lowest tap in
// the low bits; indexes of eight and above are ignored. cfg_ready is always
// high; write coefficients only while the filter is idle. History resets to
// zero and needs no clearing pass.
module fir_filter_q15_saturating_unit
  import fq15_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // input samples
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic signed [SAMP_W-1:0]    in_tdata,   // [15:0] sample_in
  // filtered samples
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic signed [SAMP_W-1:0]    out_tdata,  // [15:0] sample_out
  // coefficient writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [GROUP_W-1:0]          cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;  // ready for a sample
  localparam logic [1:0] ST_RUN  = 2'd1;  // issuing taps
  localparam logic [1:0] ST_WAIT = 2'd2;  // MAC pipeline draining
  localparam logic [1:0] ST_FIN  = 2'd3;  // write back, hand off result

  logic [1:0]                state_r, state_nxt;
  logic [TAP_W-1:0]          tap_r;
  logic [HIST_AW-1:0]        wp_r;       // slot that takes the next sample
  logic signed [SAMP_W-1:0]  x_r;        // current sample x[n]
  logic [GROUP_W-1:0]        coef_r [NUM_GROUPS];

  mac_ctl_t                  s1_ctl_r;
  logic signed [COEF_W-1:0]  s1_coef_r;

  logic [TAP_IDX_W-1:0]      tap_idx;
  logic                      tap_last;
  logic                      in_acc;
  logic                      out_free;
  logic                      fin_go;

  hist_req_t                 hreq;
  logic signed [SAMP_W-1:0]  hist_rd;
  logic signed [SAMP_W-1:0]  mac_sample;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_done;
  logic signed [ACC_W-1:0]   acc_sat;

  logic                      out_tvalid_r;
  logic signed [SAMP_W-1:0]  out_tdata_r;

  // ---------------- coefficient registers ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        coef_r[g] <= '0;
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_GROUPS))) begin
      coef_r[cfg_index[$clog2(NUM_GROUPS)-1:0]] <= cfg_data;
    end
  end

  // ---------------- sequencer ----------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tap_last  = (tap_r == TAP_W'(TAPS - 1));
  assign tap_idx   = TAP_IDX_W'(tap_r);
  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_go    = (state_r == ST_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc)   state_nxt = ST_RUN;
      ST_RUN:  if (tap_last) state_nxt = ST_WAIT;
      ST_WAIT: if (acc_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tap_r    <= '0;
      wp_r     <= '0;
      s1_ctl_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        tap_r <= '0;
      end else if (state_r == ST_RUN && !tap_last) begin
        tap_r <= tap_r + 1'b1;
      end
      if (fin_go) begin
        wp_r <= wp_r + 1'b1;
      end
      s1_ctl_r.vld   <= (state_r == ST_RUN);
      s1_ctl_r.first <= (tap_r == '0);
      s1_ctl_r.last  <= tap_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata;
    end
    // coefficient for this tap, aligned with the memory read
    s1_coef_r <= $signed(coef_r[tap_idx[TAP_IDX_W-1:2]][COEF_W*tap_idx[1:0] +: COEF_W]);
  end

  // ---------------- history ring ----------------
  // x[n-k] sits at wp - k; tap 0 uses the live sample instead
  always_comb begin
    hreq.rd_en   = (state_r == ST_RUN);
    hreq.rd_addr = wp_r - HIST_AW'(tap_idx);
    hreq.wr_en   = fin_go;
    hreq.wr_addr = wp_r;
    hreq.wr_data = x_r;
  end

  fq15_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_rd)
  );

  // ---------------- MAC ----------------
  assign mac_sample = s1_ctl_r.first ? x_r : hist_rd;

  fq15_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (s1_ctl_r),
    .sample (mac_sample),
    .coef   (s1_coef_r),
    .acc    (acc),
    .done   (acc_done)
  );

  // ---------------- saturate, scale, output register ----------------
  always_comb begin
    priority if (acc > SAT_HI) begin
      acc_sat = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc_sat = SAT_LO;
    end else begin
      acc_sat = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_tdata_r <= $signed(acc_sat[30:15]);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[dv/tb_fir_filter_q15_saturating_unit.sv]
`timescale 1ns / 1ps

module tb_fir_filter_q15_saturating_unit;
  import fq15_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  // slack on top of the request-to-result time, for the pipeline to settle
  localparam int SETTLE_CYCLES = TAPS + 8;
  // cycles with no request accepted on any port before the run is declared hung
  localparam int HANG_LIMIT   = 4000;
  localparam int SHOW_LIMIT   = 10;
  localparam int SEGMENT_LEN  = 85;
  localparam int NUM_SEGMENTS = 10;

  // Q30 accumulator bounds and the half-LSB rounding term
  localparam longint HALF_LSB = 64'sd16384;
  localparam longint Q30_MAX  = 64'sd1073741823;
  localparam longint Q30_MIN  = -64'sd1073741824;

  localparam logic [COEF_W-1:0] COEF_POS_FULL = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_NEG_FULL = 16'h8000;

  typedef enum {
    COEF_ZERO,
    COEF_FULL_POS,
    COEF_FULL_NEG,
    COEF_IMPULSE,
    COEF_SMALL,
    COEF_RANDOM
  } coef_set_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic signed [SAMP_W-1:0] in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic signed [SAMP_W-1:0] out_tdata;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [GROUP_W-1:0]       cfg_data   = '0;

  // Predictor state: coefficient registers as written, and past samples
  // (entry 0 is x[n-1]).
  logic [GROUP_W-1:0]       coef_bank    [NUM_GROUPS];
  logic signed [SAMP_W-1:0] past_samples [MAX_TAPS-1];

  logic signed [SAMP_W-1:0] pending_samples  [$];
  logic signed [SAMP_W-1:0] expected_samples [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic in_taken = 1'b0;
  int  fail_count = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  fir_filter_q15_saturating_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Filter one sample: dot product over all taps plus rounding term, clip to
  // Q30, arithmetic shift down to Q15, then push the sample into history.
  function automatic logic signed [SAMP_W-1:0] fir_next_sample(
      input logic signed [SAMP_W-1:0] x);
    longint acc;
    longint c;
    longint s;
    int     k;
    acc = HALF_LSB;
    for (k = 0; k < TAPS; k++) begin
      c = longint'($signed(coef_bank[k / LANES][(k % LANES) * COEF_W +: COEF_W]));
      s = (k == 0) ? longint'(x) : longint'(past_samples[k - 1]);
      acc += c * s;
    end
    if (acc > Q30_MAX)
      acc = Q30_MAX;
    else if (acc < Q30_MIN)
      acc = Q30_MIN;
    for (k = MAX_TAPS - 2; k > 0; k--)
      past_samples[k] = past_samples[k - 1];
    past_samples[0] = x;
    return SAMP_W'(acc >>> 15);
  endfunction

  function automatic void report_failure(input string msg);
    if (fail_count < SHOW_LIMIT)
      $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endfunction

  // Driver: new values go out on the falling edge. A sample is held until
  // the request is taken; a new one may be delayed by random idle cycles.
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      if (!in_tvalid || in_taken) begin
        if (pending_samples.size() != 0 &&
            ((send_idle_pct == 0) || ($urandom_range(99) >= send_idle_pct))) begin
          in_tdata  <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: sample both channels on the rising edge, predict on input
  // requests, check on output requests, and watch for a hang.
  always @(posedge clk) begin
    logic signed [SAMP_W-1:0] want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(fir_next_sample(in_tdata));
        samples_sent++;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_samples.size() == 0) begin
          report_failure($sformatf("unexpected result %0d, nothing pending",
                                   out_tdata));
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want)
            report_failure($sformatf("sample_out mismatch at result %0d: expected %0d, got %0d",
                                     results_seen, want, out_tdata));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[%0t] ERROR: no request accepted for %0d cycles", $time, HANG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Block until all queued samples are in, every result is out, and the
  // pipeline has had time to settle.
  task automatic wait_idle();
    do
      @(posedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write request on the coefficient port; valid stays up for the caller
  // to drop or reuse.
  task automatic write_coef_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [GROUP_W-1:0] word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do
      @(posedge clk);
    while (!cfg_ready);
    if (idx < NUM_GROUPS)
      coef_bank[idx] = word;
    cfg_writes++;
  endtask

  // Rewrite all eight groups, then hit an out-of-range index with junk that
  // must not land anywhere.
  task automatic load_coefs(input coef_set_t kind);
    logic [GROUP_W-1:0] word;
    logic [COEF_W-1:0]  c;
    int g;
    int lane;
    int hot_tap;
    hot_tap = $urandom_range(TAPS - 1);
    for (g = 0; g < NUM_GROUPS; g++) begin
      word = '0;
      for (lane = 0; lane < LANES; lane++) begin
        case (kind)
          COEF_ZERO:     c = '0;
          COEF_FULL_POS: c = COEF_POS_FULL;
          COEF_FULL_NEG: c = COEF_NEG_FULL;
          COEF_IMPULSE:  c = (g * LANES + lane == hot_tap) ? COEF_POS_FULL : '0;
          COEF_SMALL:    c = COEF_W'($urandom_range(4095)) - COEF_W'(2048);
          default:       c = COEF_W'($urandom);
        endcase
        word[lane * COEF_W +: COEF_W] = c;
      end
      write_coef_reg(CFG_IDX_W'(g), word);
    end
    write_coef_reg(CFG_IDX_W'($urandom_range(NUM_GROUPS, (1 << CFG_IDX_W) - 1)),
                   {$urandom, $urandom});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMP_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'sh0001;
    endcase
  endfunction

  // Mostly full-range noise; some isolated extremes, and runs of a held
  // extreme that drive the accumulator into the clip under large taps.
  task automatic queue_random(input int count);
    logic signed [SAMP_W-1:0] v;
    int n;
    int run;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        pending_samples.push_back(SAMP_W'($urandom));
        n++;
      end else if (r < 85) begin
        pending_samples.push_back(pick_extreme());
        n++;
      end else begin
        v   = pick_extreme();
        run = $urandom_range(4, 40);
        while (run > 0 && n < count) begin
          pending_samples.push_back(v);
          run--;
          n++;
        end
      end
    end
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    coef_set_t seg_kinds [NUM_SEGMENTS];
    int s;
    seg_kinds = '{COEF_ZERO, COEF_RANDOM, COEF_FULL_NEG, COEF_SMALL,
                  COEF_FULL_POS, COEF_RANDOM, COEF_IMPULSE,
                  COEF_SMALL, COEF_RANDOM, COEF_RANDOM};
    foreach (coef_bank[i])
      coef_bank[i] = '0;
    foreach (past_samples[i])
      past_samples[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender mostly busy, receiver stalls a lot.
    set_idle(8, 60);

    // Directed: every coefficient at -1.0. A held -32768 gives products of
    // +2^30, so the sum clips high; held +32767 clips low.
    load_coefs(COEF_FULL_NEG);
    pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF,
                        16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh5555, 16'shAAAA,
                        16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000};
    wait_idle();

    // Directed: every coefficient at the largest positive value.
    load_coefs(COEF_FULL_POS);
    pending_samples = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                        16'sh8000, 16'sh8000, 16'sh8000, 16'sh0001, 16'shFFFF};
    wait_idle();

    // Random segments, each under a fresh coefficient set. History is not
    // cleared between them, so old samples mix with the new taps.
    for (s = 0; s < NUM_SEGMENTS; s++) begin
      if (s == 4)
        set_idle(60, 8);
      else if (s == 7)
        set_idle(0, 0);
      load_coefs(seg_kinds[s]);
      queue_random(SEGMENT_LEN);
      wait_idle();
    end

    if (expected_samples.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_samples.size()));

    $display("Ran %0d samples through %0d coefficient writes, %0d results checked.",
             samples_sent, cfg_writes, results_seen);
    $display("Covered clipping both ways, impulse, small and random taps, and stalls.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
